// ===== rtl/core/kdv_pkg.sv =====
// kdv_pkg: shared types and constants for the key delta varint encoder
// no dependencies; used by every module under rtl/core
package kdv_pkg;

  localparam int unsigned DATA_W        = 64;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned GROUP_W       = 7;
  localparam int unsigned KEY_BYTES_DEF = 8;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam logic [BYTE_W-1:0]  VARINT_MORE = 8'h80;
  localparam logic [GROUP_W-1:0] VARINT_LOW7 = 7'h7F;

  typedef struct packed {
    logic [DATA_W-1:0] key_value;
    logic              first_in_block;
  } kdv_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_byte;
  } kdv_out_t;

  // queue status seen by the front and back parts
  typedef struct packed {
    logic full;
    logic not_empty;
  } kdv_q_status_t;

endpackage

// ===== rtl/core/kdv_front.sv =====
// kdv_front: masks keys, keeps the previous key and forms the 64-bit delta
// depends on kdv_pkg
module kdv_front #(
  parameter int unsigned KEY_BYTES = kdv_pkg::KEY_BYTES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  kdv_pkg::kdv_in_t            in_data_i,
  input  kdv_pkg::kdv_q_status_t      q_status_i,
  output logic                        push_o,
  output logic [kdv_pkg::DATA_W-1:0]  delta_o
);

  localparam int unsigned KEY_W = 8 * KEY_BYTES;

  logic [KEY_W-1:0] prev_q, prev_d;
  logic [KEY_W-1:0] key;
  logic [KEY_W:0]   diff;
  logic             accept;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i & ~q_status_i.full;
  assign key        = in_data_i.key_value[KEY_W-1:0];

  // difference at key width plus a sign bit, sign extended gives mod 2^64
  assign diff    = {1'b0, key} - {1'b0, prev_q};
  assign delta_o = kdv_pkg::DATA_W'($signed(diff));
  assign push_o  = accept & ~in_data_i.first_in_block;

  always_comb begin
    prev_d = prev_q;
    if (accept) begin
      prev_d = key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else begin
      prev_q <= prev_d;
    end
  end

endmodule

// ===== rtl/core/kdv_queue.sv =====
// kdv_queue: short fifo of deltas between the front and back parts
// depends on kdv_pkg
module kdv_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [kdv_pkg::DATA_W-1:0]  push_data_i,
  input  logic                        pop_i,
  output logic [kdv_pkg::DATA_W-1:0]  head_o,
  output kdv_pkg::kdv_q_status_t      status_o
);

  localparam int unsigned DEPTH = kdv_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [kdv_pkg::DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]           wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]           rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]           count_q, count_d;

  assign head_o             = mem_q[rd_ptr_q];
  assign status_o.full      = (count_q == CNT_W'(DEPTH));
  assign status_o.not_empty = (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/kdv_back.sv =====
// kdv_back: splits one delta into varint bytes, one byte per cycle while out_stall_i is low
// depends on kdv_pkg
module kdv_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  kdv_pkg::kdv_q_status_t      q_status_i,
  input  logic [kdv_pkg::DATA_W-1:0]  head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output kdv_pkg::kdv_out_t           out_data_o
);

  logic [kdv_pkg::DATA_W-1:0] rest_q, rest_d;
  logic                       act_q, act_d;
  logic                       is_last;
  logic                       take;

  // final byte once the remainder fits in seven bits
  assign is_last = ~|rest_q[kdv_pkg::DATA_W-1:kdv_pkg::GROUP_W];
  assign take    = act_q & ~out_stall_i;
  assign pop_o   = q_status_i.not_empty & (~act_q | (take & is_last));

  assign out_valid_o          = act_q;
  assign out_data_o.last_byte = is_last;
  assign out_data_o.out_byte  = is_last ? rest_q[kdv_pkg::BYTE_W-1:0]
      : (kdv_pkg::VARINT_MORE
         | {1'b0, rest_q[kdv_pkg::GROUP_W-1:0] & kdv_pkg::VARINT_LOW7});

  always_comb begin
    rest_d = rest_q;
    act_d  = act_q;
    if (pop_o) begin
      rest_d = head_i;
      act_d  = 1'b1;
    end else if (take) begin
      if (is_last) begin
        act_d = 1'b0;
      end else begin
        rest_d = rest_q >> kdv_pkg::GROUP_W;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else begin
      act_q <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rest_q <= rest_d;
  end

endmodule

// ===== rtl/core/key_delta_varint_encoder.sv =====
// key_delta_varint_encoder: top level of the key delta varint encoder
// depends on kdv_pkg, kdv_front, kdv_queue, kdv_back
//
// channel | direction | handshake               | payload
// --------+-----------+-------------------------+-------------------------------
// in      | input     | in_valid_i / in_stall_o | kdv_in_t: key_value, first_in_block
// out     | output    | out_valid_o/out_stall_i | kdv_out_t: out_byte, last_byte
//
// a key enters when in_valid_i is high and in_stall_o is low; its delta then
// becomes 1 to 10 varint bytes in the back serializer, which loads the next
// delta as it emits the last byte; a block-start key emits nothing and only
// updates the previous key; the two-entry delta queue lets the front keep
// taking keys while the back is stalled; in_stall_o rises when the queue is full
// reset clears the previous key to zero and empties the queue
module key_delta_varint_encoder #(
  parameter int unsigned KEY_BYTES = kdv_pkg::KEY_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  kdv_pkg::kdv_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output kdv_pkg::kdv_out_t  out_data_o
);

  kdv_pkg::kdv_q_status_t     q_status;
  logic                       push;
  logic                       pop;
  logic [kdv_pkg::DATA_W-1:0] delta;
  logic [kdv_pkg::DATA_W-1:0] head;

  // front: mask key, subtract previous key, update previous key
  kdv_front #(
    .KEY_BYTES (KEY_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_status_i (q_status),
    .push_o     (push),
    .delta_o    (delta)
  );

  // queue of pending deltas
  kdv_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (delta),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (q_status)
  );

  // back: emit seven bits per byte, low group first
  kdv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench for key_delta_varint_encoder
// depends on kdv_pkg and the encoder rtl; keeps its own delta/varint predictor
// directed table first, then random sorted key blocks mixed with unsorted noise
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned KEY_BYTES   = kdv_pkg::KEY_BYTES_DEF;
  localparam int unsigned DATA_W      = kdv_pkg::DATA_W;
  localparam int unsigned BYTE_W      = kdv_pkg::BYTE_W;
  localparam int unsigned GROUP_W     = kdv_pkg::GROUP_W;
  localparam int          DIR_ROWS    = 21;
  localparam int          RAND_ITEMS  = 330;
  localparam int          HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int          HOLD_AFTER  = 150;   // bytes checked before the hold starts
  localparam int          DRAIN_CYC   = 40;    // quiet cycles after the last byte
  localparam int          MAX_VARINT  = 10;

  // one planned input transaction; typed rows carry their expected bytes
  typedef struct packed {
    kdv_pkg::kdv_in_t item;
    logic             typed;
    logic [3:0]       n_typed;
    logic [79:0]      typed_bytes;  // byte i at [8*i +: 8]
  } key_plan_t;

  // receiver stall patterns
  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic              clk;
  logic              rst_n;
  logic              in_valid  = 1'b0;
  kdv_pkg::kdv_in_t  in_data   = '0;
  logic              out_stall = 1'b0;
  logic              in_stall_o;
  logic              out_valid_o;
  kdv_pkg::kdv_out_t out_data_o;

  key_plan_t directed_tbl [DIR_ROWS];
  key_plan_t plan [$];

  // predictor state and expected varint bytes in arrival order
  logic [DATA_W-1:0] pred_key = '0;
  kdv_pkg::kdv_out_t pending_bytes [$];

  int err_cnt       = 0;
  int in_taken      = 0;
  int starts_taken  = 0;
  int bytes_checked = 0;
  int longest_vint  = 0;
  int stall_seen    = 0;

  key_delta_varint_encoder #(
    .KEY_BYTES(KEY_BYTES)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // single reset pulse at the start of the run
  initial begin
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

  function automatic key_plan_t plan_row(logic [63:0] key, logic first, logic typed,
                                         logic [3:0] n, logic [79:0] bytes);
    key_plan_t r;
    r.item.key_value      = key;
    r.item.first_in_block = first;
    r.typed               = typed;
    r.n_typed             = n;
    r.typed_bytes         = bytes;
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // low nbits set, nbits in 0..64
  function automatic logic [63:0] low_mask(int nbits);
    if (nbits >= 64) return '1;
    return (64'h1 << nbits) - 64'h1;
  endfunction

  // take one key into the predictor: update the previous key and queue the
  // varint bytes of the delta, or the typed bytes where the row has them
  task automatic encode_key(kdv_pkg::kdv_in_t item, key_plan_t row);
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] rest;
    kdv_pkg::kdv_out_t b;
    int                cnt;
    bit                done;
    key  = item.key_value & ({DATA_W{1'b1}} >> (DATA_W - BYTE_W * KEY_BYTES));
    cnt  = 0;
    done = 1'b0;
    if (item.first_in_block) begin
      // block start only stores the key
      pred_key = key;
      starts_taken++;
    end else begin
      rest     = key - pred_key;  // wraps modulo 2^64
      pred_key = key;
      if (row.typed) begin
        for (int i = 0; i < row.n_typed; i++) begin
          b.out_byte  = row.typed_bytes[8*i +: 8];
          b.last_byte = (i == row.n_typed - 1);
          pending_bytes = {pending_bytes, b};
        end
        cnt = row.n_typed;
      end else begin
        while (!done && cnt < MAX_VARINT) begin
          if (rest < DATA_W'(kdv_pkg::VARINT_MORE)) begin
            b.out_byte  = rest[BYTE_W-1:0];
            b.last_byte = 1'b1;
            done        = 1'b1;
          end else begin
            b.out_byte  = kdv_pkg::VARINT_MORE
                          | {1'b0, rest[GROUP_W-1:0] & kdv_pkg::VARINT_LOW7};
            b.last_byte = 1'b0;
            rest        = rest >> GROUP_W;
          end
          pending_bytes = {pending_bytes, b};
          cnt++;
        end
      end
      if (cnt > longest_vint) longest_vint = cnt;
    end
  endtask

  // monitor and scoreboard: sampled at the edge, before any tb drive lands
  always @(posedge clk) begin
    kdv_pkg::kdv_out_t want;
    if (rst_n) begin
      if (in_valid && in_stall_o) stall_seen++;
      // input transaction accepted: predict before checking outputs
      if (in_valid && !in_stall_o) begin
        encode_key(in_data, plan[in_taken]);
        in_taken++;
      end
      if (out_valid_o && !out_stall) begin
        if (pending_bytes.size() == 0) begin
          $error("unexpected varint byte %h last %b", out_data_o.out_byte,
                 out_data_o.last_byte);
          err_cnt++;
        end else begin
          want = pending_bytes.pop_front();
          if (out_data_o.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, out_data_o.out_byte);
            err_cnt++;
          end
          if (out_data_o.last_byte !== want.last_byte) begin
            $error("last_byte: expected %b, got %b", want.last_byte, out_data_o.last_byte);
            err_cnt++;
          end
        end
        bytes_checked++;
      end
    end
  end

  // receiver: changes stall pattern now and then, with one long hold-off
  // that backs the delta queue up and pushes in_stall_o high
  initial begin : receiver
    stall_mode_e mode;
    int          mode_left;
    int          hold_left;
    bit          hold_done;
    mode      = STALL_NONE;
    mode_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!hold_done && bytes_checked >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(5, 60);
        end
        mode_left--;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
          default:     out_stall <= (mode_left % 3 == 0);
        endcase
      end
    end
  end

  initial begin : main
    int          send_idx;
    int          burst_left;
    int          gap_left;
    int          blk_len;
    int          nbits;
    logic [63:0] key;

    // directed rows: typed bytes only where the answer is obvious
    // after reset, delta against zero
    directed_tbl[0]  = plan_row(64'd5, 1'b0, 1'b1, 4'd1, 80'h05);
    // equal keys give a single zero byte
    directed_tbl[1]  = plan_row(64'd5, 1'b0, 1'b1, 4'd1, 80'h00);
    // smaller key wraps to a ten byte varint
    directed_tbl[2]  = plan_row(64'd0, 1'b0, 1'b0, 4'd0, 80'h0);
    directed_tbl[3]  = plan_row('1, 1'b1, 1'b1, 4'd0, 80'h0);
    // zero minus all ones is one
    directed_tbl[4]  = plan_row(64'd0, 1'b0, 1'b1, 4'd1, 80'h01);
    // largest delta: nine 0xff then 0x01
    directed_tbl[5]  = plan_row('1, 1'b0, 1'b1, 4'd10, 80'h01_ff_ff_ff_ff_ff_ff_ff_ff_ff);
    directed_tbl[6]  = plan_row(64'd0, 1'b1, 1'b1, 4'd0, 80'h0);
    // largest single byte, then smallest two byte value
    directed_tbl[7]  = plan_row(64'h7f, 1'b0, 1'b1, 4'd1, 80'h7f);
    directed_tbl[8]  = plan_row(64'hff, 1'b0, 1'b1, 4'd2, 80'h01_80);
    directed_tbl[9]  = plan_row(64'h40ff, 1'b0, 1'b0, 4'd0, 80'h0);
    directed_tbl[10] = plan_row(64'h8000_0000_0000_0000, 1'b1, 1'b1, 4'd0, 80'h0);
    directed_tbl[11] = plan_row(64'h8000_0000_0000_0000, 1'b0, 1'b1, 4'd1, 80'h00);
    directed_tbl[12] = plan_row('1, 1'b0, 1'b0, 4'd0, 80'h0);
    directed_tbl[13] = plan_row(64'h0123_4567_89ab_cdef, 1'b1, 1'b1, 4'd0, 80'h0);
    directed_tbl[14] = plan_row(64'hfedc_ba98_7654_3210, 1'b0, 1'b0, 4'd0, 80'h0);
    // back to back block starts
    directed_tbl[15] = plan_row(64'haaaa_aaaa_aaaa_aaaa, 1'b1, 1'b1, 4'd0, 80'h0);
    directed_tbl[16] = plan_row(64'h5555_5555_5555_5555, 1'b1, 1'b1, 4'd0, 80'h0);
    directed_tbl[17] = plan_row(64'haaaa_aaaa_aaaa_aaaa, 1'b0, 1'b0, 4'd0, 80'h0);
    directed_tbl[18] = plan_row(64'd0, 1'b0, 1'b0, 4'd0, 80'h0);
    directed_tbl[19] = plan_row(64'h80, 1'b0, 1'b1, 4'd2, 80'h01_80);
    // delta of exactly 2^63
    directed_tbl[20] = plan_row(64'h8000_0000_0000_0080, 1'b0, 1'b0, 4'd0, 80'h0);
    for (int i = 0; i < DIR_ROWS; i++) plan = {plan, directed_tbl[i]};

    // random part: mostly sorted blocks, some unsorted noise
    while (plan.size() < DIR_ROWS + RAND_ITEMS) begin
      if ($urandom_range(0, 9) < 8) begin
        case ($urandom_range(0, 3))
          0:       key = 64'd0;
          1:       key = '1 - 64'($urandom_range(0, 255));
          default: key = rand64();
        endcase
        plan = {plan, plan_row(key, 1'b1, 1'b0, 4'd0, 80'h0)};
        blk_len = $urandom_range(1, 12);
        for (int k = 0; k < blk_len; k++) begin
          // short deltas dominate, long ones reach every varint length
          nbits = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 14) : $urandom_range(15, 64);
          key   = key + (rand64() & low_mask(nbits));
          plan  = {plan, plan_row(key, 1'b0, 1'b0, 4'd0, 80'h0)};
        end
      end else begin
        blk_len = $urandom_range(1, 6);
        for (int k = 0; k < blk_len; k++) begin
          plan = {plan, plan_row(rand64(), ($urandom_range(0, 3) == 0), 1'b0, 4'd0,
                                 80'h0)};
        end
      end
    end

    send_idx   = 0;
    burst_left = 0;
    gap_left   = 0;
    wait (rst_n === 1'b1);

    // sender: bursts of transactions with random gaps, payload held while stalled
    while (send_idx < plan.size()) begin
      @(posedge clk);
      if (in_valid && !in_stall_o) send_idx++;
      if (in_valid && in_stall_o) begin
        // stalled: keep valid and payload as they are
      end else if (send_idx >= plan.size()) begin
        in_valid <= 1'b0;
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else begin
        in_valid <= 1'b1;
        in_data  <= plan[send_idx].item;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 20);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end

    // let the monitor take the last key, then wait out the remaining bytes
    // and a quiet stretch for stray output
    while (in_taken < plan.size()) @(posedge clk);
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("covered %0d keys (%0d block starts), %0d varint bytes checked",
             in_taken, starts_taken, bytes_checked);
    $display("longest varint %0d bytes, input held off for %0d cycles",
             longest_vint, stall_seen);
    if (err_cnt == 0 && pending_bytes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
